// ===== rtl/bilat_pkg.sv =====
// Shared constants and types for the bilinear alpha texture test.
// No dependencies; every other file in rtl/ but bilat_ram uses this package.
package bilat_pkg;

	localparam int COORD_W   = 17;
	localparam int FRAC_W    = 16;
	localparam int IDX_W     = 14;
	localparam int VAL_W     = 8;
	localparam int CFG_IDX_W = 2;

	// Q1.16 one, and widths of the Q8.16 row values and the Q8.32 sum
	localparam logic [FRAC_W:0] FRAC_ONE = 17'h1_0000;
	localparam int TOP_W = VAL_W + FRAC_W;
	localparam int SUM_W = VAL_W + 2 * FRAC_W;

	localparam logic [VAL_W-1:0] THR_RESET = 8'd128;

	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH     = 2'd0,
		REG_HEIGHT    = 2'd1,
		REG_THRESHOLD = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		KIND_LOAD   = 1'b0,
		KIND_SAMPLE = 1'b1
	} kind_t;

endpackage

// ===== rtl/bilat_if.sv =====
// Channel interfaces: request items, result items and configuration writes.
// Depends on bilat_pkg.
interface bilat_req_if;
	logic                           valid;
	logic                           ready;
	logic                           kind;
	logic [bilat_pkg::IDX_W-1:0]    texel_index;
	logic [bilat_pkg::VAL_W-1:0]    texel_value;
	logic [bilat_pkg::COORD_W-1:0]  u;
	logic [bilat_pkg::COORD_W-1:0]  v;

	modport source (output valid, kind, texel_index, texel_value, u, v, input ready);
	modport sink   (input valid, kind, texel_index, texel_value, u, v, output ready);
endinterface

interface bilat_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [bilat_pkg::VAL_W-1:0] alpha;
	logic                        opaque;

	modport source (output valid, alpha, opaque, input ready);
	modport sink   (input valid, alpha, opaque, output ready);
endinterface

interface bilat_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [bilat_pkg::CFG_IDX_W-1:0] index;
	logic [bilat_pkg::VAL_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/bilinear_alpha_texture_test.sv =====
// Bilinear alpha texture test with clamp-to-edge addressing. Takes one request
// transaction per clock unless the result side stalls: a load writes one texel
// into the texture store and returns nothing; a sample scales u/v (Q1.16) by
// the configured width and height, fetches the 2x2 neighbourhood, blends
// bilinearly with 17-bit weights, rounds half up and returns alpha with an
// opaque flag (alpha >= threshold). Sustained rate is one transaction per
// cycle while the result side is not stalling. The rate is set by the store:
// two copies of MAX_SIDE*MAX_SIDE bytes, each with one write and two read
// ports, give all four neighbour reads in one cycle. A four-entry queue separates
// intake from the store/blend pipeline. The store has no reset or clearing
// pass; sample only texels already loaded. The user must write configuration
// only while no transaction is in flight; the block does not enforce it.
module bilinear_alpha_texture_test #(
	parameter int MAX_SIDE = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	bilat_req_if.sink   req,
	bilat_rsp_if.source rsp,
	bilat_cfg_if.sink   cfg
);
	import bilat_pkg::*;

	localparam int AW    = $clog2(MAX_SIDE * MAX_SIDE);
	localparam int ENT_W = 2 + 2 * AW + 2 * FRAC_W + VAL_W;

	logic             push;
	logic             pop;
	logic             q_full;
	logic             q_empty;
	logic [ENT_W-1:0] ent_in;
	logic [ENT_W-1:0] ent_out;
	logic [VAL_W-1:0] thr;

	bilat_front #(.MAX_SIDE(MAX_SIDE)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cfg      (cfg),
		.thr      (thr),
		.push     (push),
		.ent_data (ent_in),
		.q_full   (q_full)
	);

	bilat_queue #(.W(ENT_W)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (ent_in),
		.full   (q_full),
		.pop    (pop),
		.rdata  (ent_out),
		.empty  (q_empty)
	);

	bilat_back #(.MAX_SIDE(MAX_SIDE)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.thr      (thr),
		.q_empty  (q_empty),
		.ent_data (ent_out),
		.pop      (pop),
		.rsp      (rsp)
	);

endmodule

// ===== rtl/bilat_ram.sv =====
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
module bilat_ram #(
	parameter int W     = 8,
	parameter int DEPTH = 16384,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr_a,
	input  logic [AW-1:0] raddr_b,
	output logic [W-1:0]  rdata_a,
	output logic [W-1:0]  rdata_b
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

// ===== rtl/bilat_queue.sv =====
// Short FIFO between the front end and the back end.
// Depends on bilat_pkg.
module bilat_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);
	import bilat_pkg::*;

	logic [W-1:0]       mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_PTR_W:0]   cnt_q;

	assign full  = (cnt_q == (Q_PTR_W + 1)'(Q_DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue pushed while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("queue popped while empty");
`endif

endmodule

// ===== rtl/bilat_front.sv =====
// Front end: configuration registers, request intake, coordinate scaling,
// clamp-to-edge and store addressing. Depends on bilat_pkg, bilat_if.
module bilat_front #(
	parameter int MAX_SIDE = 128,
	localparam int SW      = $clog2(MAX_SIDE + 1),
	localparam int CW      = $clog2(MAX_SIDE),
	localparam int AW      = $clog2(MAX_SIDE * MAX_SIDE),
	localparam int DEPTH   = MAX_SIDE * MAX_SIDE,
	localparam int ENT_W   = 2 + 2 * AW + 2 * bilat_pkg::FRAC_W + bilat_pkg::VAL_W
) (
	input  logic                        clk,
	input  logic                        arst_n,
	bilat_req_if.sink                   req,
	bilat_cfg_if.sink                   cfg,
	output logic [bilat_pkg::VAL_W-1:0] thr,
	output logic                        push,
	output logic [ENT_W-1:0]            ent_data,
	input  logic                        q_full
);
	import bilat_pkg::*;

	localparam int PW = COORD_W + SW;
	localparam int IW = (AW > IDX_W) ? AW : IDX_W;

	typedef struct packed {
		logic              is_smp;
		logic [AW-1:0]     addr_t;
		logic [AW-1:0]     addr_b;
		logic              dx;
		logic [FRAC_W-1:0] fx;
		logic [FRAC_W-1:0] fy;
		logic [VAL_W-1:0]  value;
	} ent_t;

	function automatic logic [SW-1:0] eff_side(input logic [VAL_W-1:0] r);
		if (r == '0) begin
			return SW'(1);
		end else if (int'(r) > MAX_SIDE) begin
			return SW'(MAX_SIDE);
		end
		return SW'(r);
	endfunction

	logic [SW-1:0]    w_q;
	logic [SW-1:0]    h_q;
	logic [VAL_W-1:0] thr_q;

	logic             s1_valid_q;
	logic             is_smp_s1;
	logic [AW-1:0]    idx_s1;
	logic [VAL_W-1:0] val_s1;
	logic [PW-1:0]    px_s1;
	logic [PW-1:0]    py_s1;

	logic             acc;
	logic             in_range;
	logic [IW-1:0]    idx_ext;
	logic [SW:0]      ix;
	logic [SW:0]      iy;
	logic [CW-1:0]    x0;
	logic [CW-1:0]    y0;
	logic [CW-1:0]    y1;
	logic             dx;
	logic             dy;
	ent_t             ent;

	// configuration: always ready, sizes stored already clamped
	assign cfg.ready = 1'b1;
	assign thr       = thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q   <= SW'(1);
			h_q   <= SW'(1);
			thr_q <= THR_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_WIDTH:     w_q   <= eff_side(cfg.data);
				REG_HEIGHT:    h_q   <= eff_side(cfg.data);
				REG_THRESHOLD: thr_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// intake; loads outside the store are dropped here
	assign req.ready = !s1_valid_q || !q_full;
	assign acc       = req.valid && req.ready;
	assign idx_ext   = IW'(req.texel_index);
	assign in_range  = int'(req.texel_index) < DEPTH;
	assign push      = s1_valid_q && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (req.ready) begin
			s1_valid_q <= req.valid && (req.kind == KIND_SAMPLE || in_range);
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			is_smp_s1 <= (req.kind == KIND_SAMPLE);
			idx_s1    <= idx_ext[AW-1:0];
			val_s1    <= req.texel_value;
			px_s1     <= PW'(req.u) * PW'(w_q);
			py_s1     <= PW'(req.v) * PW'(h_q);
		end
	end

	// texel coordinates, clamped to the last column or row
	assign ix = px_s1[PW-1:FRAC_W];
	assign iy = py_s1[PW-1:FRAC_W];
	assign x0 = (ix >= {1'b0, w_q}) ? CW'(w_q - 1'b1) : CW'(ix);
	assign y0 = (iy >= {1'b0, h_q}) ? CW'(h_q - 1'b1) : CW'(iy);
	assign dx = (ix + 1'b1) < {1'b0, w_q};
	assign dy = (iy + 1'b1) < {1'b0, h_q};
	assign y1 = dy ? CW'(y0 + 1'b1) : y0;

	always_comb begin
		ent.is_smp = is_smp_s1;
		ent.dx     = dx;
		ent.fx     = px_s1[FRAC_W-1:0];
		ent.fy     = py_s1[FRAC_W-1:0];
		ent.value  = val_s1;
		if (is_smp_s1) begin
			ent.addr_t = AW'(y0) * AW'(w_q) + AW'(x0);
			ent.addr_b = AW'(y1) * AW'(w_q) + AW'(x0);
		end else begin
			ent.addr_t = idx_s1;
			ent.addr_b = idx_s1;
		end
	end

	assign ent_data = ent;

`ifndef SYNTH
	a_addr_in_store: assert property (@(posedge clk) disable iff (!arst_n)
		(push && ent.is_smp) |-> ((int'(ent.addr_b) + int'(ent.dx)) < DEPTH
			&& ent.addr_b >= ent.addr_t))
		else $error("sample neighbourhood outside the store");
`endif

endmodule

// ===== rtl/bilat_back.sv =====
// Back end: texture store writes and 2x2 reads, bilinear blend, rounding,
// threshold compare and the result register. Depends on bilat_pkg, bilat_if, bilat_ram.
module bilat_back #(
	parameter int MAX_SIDE = 128,
	localparam int AW      = $clog2(MAX_SIDE * MAX_SIDE),
	localparam int DEPTH   = MAX_SIDE * MAX_SIDE,
	localparam int ENT_W   = 2 + 2 * AW + 2 * bilat_pkg::FRAC_W + bilat_pkg::VAL_W
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [bilat_pkg::VAL_W-1:0] thr,
	input  logic                        q_empty,
	input  logic [ENT_W-1:0]            ent_data,
	output logic                        pop,
	bilat_rsp_if.source                 rsp
);
	import bilat_pkg::*;

	typedef struct packed {
		logic              is_smp;
		logic [AW-1:0]     addr_t;
		logic [AW-1:0]     addr_b;
		logic              dx;
		logic [FRAC_W-1:0] fx;
		logic [FRAC_W-1:0] fy;
		logic [VAL_W-1:0]  value;
	} ent_t;

	ent_t              ent;
	logic              en;
	logic              we;
	logic              re;
	logic [VAL_W-1:0]  c00;
	logic [VAL_W-1:0]  c10;
	logic [VAL_W-1:0]  c01;
	logic [VAL_W-1:0]  c11;

	logic              b1_valid_q;
	logic [FRAC_W-1:0] fx_s1;
	logic [FRAC_W-1:0] fy_s1;
	logic              b2_valid_q;
	logic [TOP_W-1:0]  top_s2;
	logic [TOP_W-1:0]  bot_s2;
	logic [FRAC_W-1:0] fy_s2;
	logic              b3_valid_q;
	logic [SUM_W-1:0]  sum_s3;
	logic              out_valid_q;
	logic [VAL_W-1:0]  alpha_q;
	logic              opaque_q;

	logic [FRAC_W:0]   wx0;
	logic [FRAC_W:0]   wx1;
	logic [FRAC_W:0]   wy0;
	logic [FRAC_W:0]   wy1;
	logic [TOP_W:0]    top_c;
	logic [TOP_W:0]    bot_c;
	logic [SUM_W:0]    sum_c;
	logic [VAL_W-1:0]  alpha_c;

	assign ent = ent_t'(ent_data);
	// whole back end moves together; it stalls only on a held result
	assign en  = !out_valid_q || rsp.ready;
	assign pop = !q_empty && en;
	assign we  = pop && !ent.is_smp;
	assign re  = pop && ent.is_smp;

	// one copy of the texture per row of the neighbourhood
	bilat_ram #(.W(VAL_W), .DEPTH(DEPTH)) u_ram_top (
		.clk     (clk),
		.we      (we),
		.waddr   (ent.addr_t),
		.wdata   (ent.value),
		.re      (re),
		.raddr_a (ent.addr_t),
		.raddr_b (ent.addr_t + AW'(ent.dx)),
		.rdata_a (c00),
		.rdata_b (c10)
	);

	bilat_ram #(.W(VAL_W), .DEPTH(DEPTH)) u_ram_bot (
		.clk     (clk),
		.we      (we),
		.waddr   (ent.addr_t),
		.wdata   (ent.value),
		.re      (re),
		.raddr_a (ent.addr_b),
		.raddr_b (ent.addr_b + AW'(ent.dx)),
		.rdata_a (c01),
		.rdata_b (c11)
	);

	assign wx1   = {1'b0, fx_s1};
	assign wx0   = FRAC_ONE - wx1;
	assign wy1   = {1'b0, fy_s2};
	assign wy0   = FRAC_ONE - wy1;
	assign top_c = (TOP_W + 1)'(c00) * (TOP_W + 1)'(wx0)
		+ (TOP_W + 1)'(c10) * (TOP_W + 1)'(wx1);
	assign bot_c = (TOP_W + 1)'(c01) * (TOP_W + 1)'(wx0)
		+ (TOP_W + 1)'(c11) * (TOP_W + 1)'(wx1);
	assign sum_c = (SUM_W + 1)'(top_s2) * (SUM_W + 1)'(wy0)
		+ (SUM_W + 1)'(bot_s2) * (SUM_W + 1)'(wy1);
	// round half up; the sum never exceeds 255.0 so no carry out
	assign alpha_c = sum_s3[SUM_W-1 -: VAL_W] + VAL_W'(sum_s3[2 * FRAC_W - 1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b1_valid_q  <= 1'b0;
			b2_valid_q  <= 1'b0;
			b3_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			b1_valid_q  <= re;
			b2_valid_q  <= b1_valid_q;
			b3_valid_q  <= b2_valid_q;
			out_valid_q <= b3_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			fx_s1 <= ent.fx;
			fy_s1 <= ent.fy;
		end
		if (en) begin
			top_s2   <= top_c[TOP_W-1:0];
			bot_s2   <= bot_c[TOP_W-1:0];
			fy_s2    <= fy_s1;
			sum_s3   <= sum_c[SUM_W-1:0];
			alpha_q  <= alpha_c;
			opaque_q <= (alpha_c >= thr);
		end
	end

	assign rsp.valid  = out_valid_q;
	assign rsp.alpha  = alpha_q;
	assign rsp.opaque = opaque_q;

`ifndef SYNTH
	a_texels_held: assert property (@(posedge clk) disable iff (!arst_n)
		(b1_valid_q && !en) |=> ($stable(c00) && $stable(c10) && $stable(c01)
			&& $stable(c11)))
		else $error("texel read data lost during stall");
`endif

endmodule
